FILE: rtl/lbp_pkg.sv
// Package for the LD block pair weight pruner.
// Holds the channel payload types, the configuration set, codes and reset values.
// Used by lbp_front, lbp_back and ld_block_pair_weight_pruner.
`default_nettype none

package lbp_pkg;

  // One input item as it arrives on the input queue port.
  typedef struct packed {
    logic               cmd;
    logic [12:0]        marker_count;
    logic signed [15:0] ci_lower;
    logic signed [15:0] ci_upper;
    logic               ci_valid;
    logic [31:0]        pair_span_bp;
  } lbp_item_t;

  // One result item as it leaves on the result queue port.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] first_marker;
    logic [11:0] second_marker;
    logic [31:0] span_bp;
    logic        last;
  } lbp_result_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic        is_start;
    logic [12:0] marker_count;
    logic        strong_pair;
    logic        recomb;
    logic [31:0] span;
  } lbp_cmd_t;

  // Configuration register set.
  typedef struct packed {
    logic signed [15:0] strong_pos_lower_min;
    logic signed [15:0] strong_pos_upper_min;
    logic signed [15:0] strong_neg_upper_max;
    logic signed [15:0] strong_neg_lower_max;
    logic signed [15:0] recomb_lower_min;
    logic signed [15:0] recomb_upper_max;
    logic [15:0]        strong_weight;
    logic [15:0]        recomb_weight;
  } lbp_cfg_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } lbp_state_t;

  // Command codes.
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_ANSWER = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_BLOCK   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_STRONG_POS_LOWER_MIN = 3'd0;
  localparam logic [2:0] REG_STRONG_POS_UPPER_MIN = 3'd1;
  localparam logic [2:0] REG_STRONG_NEG_UPPER_MAX = 3'd2;
  localparam logic [2:0] REG_STRONG_NEG_LOWER_MAX = 3'd3;
  localparam logic [2:0] REG_RECOMB_LOWER_MIN     = 3'd4;
  localparam logic [2:0] REG_RECOMB_UPPER_MAX     = 3'd5;
  localparam logic [2:0] REG_STRONG_WEIGHT        = 3'd6;
  localparam logic [2:0] REG_RECOMB_WEIGHT        = 3'd7;

  // Configuration reset values.
  localparam lbp_cfg_t CFG_RESET = '{
    strong_pos_lower_min: 16'sd22938,
    strong_pos_upper_min: 16'sd32113,
    strong_neg_upper_max: -16'sd22938,
    strong_neg_lower_max: -16'sd32113,
    recomb_lower_min:     -16'sd29491,
    recomb_upper_max:     16'sd29491,
    strong_weight:        16'd3277,
    recomb_weight:        16'd62259
  };

endpackage

`default_nettype wire

FILE: rtl/lbp_front.sv
// Front end of the LD block pair weight pruner: accepts input items,
// classifies the interval answer and queues commands for the back end.
// Depends on lbp_pkg.
`default_nettype none

module lbp_front
  import lbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire lbp_item_t item,
  input  wire lbp_cfg_t  cfg,
  output logic           cmd_valid,
  output lbp_cmd_t       cmd,
  input  wire logic      cmd_take
);

  logic signed [15:0] lo;
  logic signed [15:0] hi;
  logic               strong_pair;
  logic               recomb;
  lbp_cmd_t           entry;
  lbp_cmd_t           q [2];
  logic               rd_ptr;
  logic               wr_ptr;
  logic [1:0]         count;
  logic               do_push;
  logic               do_pop;

  // Classify the pair with exact signed compares.
  assign lo = item.ci_lower;
  assign hi = item.ci_upper;
  assign strong_pair = item.ci_valid &&
                  ((lo >= cfg.strong_pos_lower_min && hi >= cfg.strong_pos_upper_min) ||
                   (lo <= cfg.strong_neg_upper_max && hi <= cfg.strong_neg_lower_max));
  assign recomb = item.ci_valid && !strong_pair &&
                  lo >= cfg.recomb_lower_min && hi <= cfg.recomb_upper_max;

  always_comb begin
    entry.is_start     = (item.cmd == CMD_START);
    entry.marker_count = item.marker_count;
    entry.strong_pair  = strong_pair;
    entry.recomb       = recomb;
    entry.span         = item.pair_span_bp;
  end

  // Two-entry command queue toward the back end.
  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (!do_push && do_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lbp_back.sv
// Back end of the LD block pair weight pruner: pair scan sequencer,
// weight memory read-modify-write, floor bound and result queue.
// Depends on lbp_pkg.
`default_nettype none

module lbp_back
  import lbp_pkg::*;
#(
  parameter int MAX_MARKERS  = 4096,
  parameter int WEIGHT_WIDTH = 48
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lbp_cfg_t cfg,
  input  wire logic     cmd_valid,
  input  wire lbp_cmd_t cmd,
  output logic          cmd_take,
  input  wire logic     pop,
  output logic          empty,
  output lbp_result_t   result
);

  localparam int IW   = (MAX_MARKERS > 2) ? $clog2(MAX_MARKERS) : 1;
  localparam int CW   = $clog2(MAX_MARKERS + 1);
  localparam int WW   = WEIGHT_WIDTH;
  localparam int PW   = 2 * CW + 1;
  localparam int HW   = PW + 16;
  localparam int CMPW = (WW + 1 > HW) ? WW + 1 : HW;
  localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

  function automatic logic signed [WW-1:0] sat_add(input logic signed [WW-1:0] a,
                                                   input logic signed [WW-1:0] b);
    logic signed [WW:0] s;
    s = {a[WW-1], a} + {b[WW-1], b};
    if (s[WW] != s[WW-1]) begin
      return s[WW] ? WMIN : WMAX;
    end
    return s[WW-1:0];
  endfunction

  lbp_state_t         state;
  lbp_state_t         state_next;
  logic               busy;
  logic [CW-1:0]      n_cnt;
  logic [IW-1:0]      row_index;
  logic [IW-1:0]      col_index;
  logic [IW-1:0]      row_floor;
  logic [IW-1:0]      next_row_floor;
  logic signed [WW-1:0] row_sum;
  lbp_cmd_t           cur;
  logic [PW-1:0]      p_prod;
  logic [HW-1:0]      bound;
  logic signed [WW-1:0] w_val;
  logic signed [WW-1:0] rd_data;
  logic signed [WW-1:0] mem [MAX_MARKERS];
  lbp_result_t        oq [2];
  logic [1:0]         out_cnt;

  logic [CW-1:0]      n_sat;
  logic               fresh;
  logic signed [WW-1:0] w_old;
  logic signed [WW-1:0] w_new;
  logic signed [WW-1:0] row_sum_upd;
  logic [CW-1:0]      p_left;
  logic [CW:0]        p_right;
  logic [WW:0]        w_mag;
  logic               floor_ok;
  logic [IW-1:0]      nrf_upd;
  logic               rd_en;
  logic               wr_en;
  logic               out_push;
  logic [1:0]         out_n;
  lbp_result_t        res_a;
  lbp_result_t        res_b;
  lbp_result_t        res_next;

  // Saturated marker count on a start.
  assign n_sat = (32'(cmd.marker_count) > 32'(MAX_MARKERS)) ? CW'(MAX_MARKERS)
                                                             : CW'(cmd.marker_count);

  // Running row sum after this answer.
  always_comb begin
    if (cmd.strong_pair) begin
      row_sum_upd = sat_add(row_sum, WW'(cfg.strong_weight));
    end else if (cmd.recomb) begin
      row_sum_upd = sat_add(row_sum, -WW'(cfg.recomb_weight));
    end else begin
      row_sum_upd = row_sum;
    end
  end

  // First factor pair of the optimistic bound.
  assign p_left  = n_cnt - CW'(row_index) - CW'(1);
  assign p_right = (CW+1)'(n_cnt) + (CW+1)'(row_index) - ((CW+1)'(col_index) << 1);

  // The entry just below the row is touched first in this run, so it reads as zero.
  assign fresh = (col_index == row_index - IW'(1));
  assign w_old = fresh ? '0 : rd_data;
  assign w_new = sat_add(w_old, row_sum);

  // Floor test: weight non-negative or its magnitude within the bound.
  assign w_mag    = (WW+1)'(0) - {w_val[WW-1], w_val};
  assign floor_ok = !w_val[WW-1] || (CMPW'(w_mag) <= CMPW'(bound));
  assign nrf_upd  = floor_ok ? col_index : next_row_floor;

  // Request or completion that closes an answer.
  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    if (col_index > row_floor) begin
      res_next.kind          = KIND_REQUEST;
      res_next.first_marker  = 12'(col_index - IW'(1));
      res_next.second_marker = 12'(row_index);
    end else if ((CW'(row_index) + CW'(1)) < n_cnt) begin
      res_next.kind          = KIND_REQUEST;
      res_next.first_marker  = 12'(row_index);
      res_next.second_marker = 12'(row_index + IW'(1));
    end else begin
      res_next.kind = KIND_DONE;
    end
  end

  // Sequencer: next state and handshakes.
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    out_push   = 1'b0;
    out_n      = 2'd1;
    res_a      = '0;
    res_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_cnt == 2'd0) begin
          cmd_take = 1'b1;
          if (cmd.is_start) begin
            out_push = 1'b1;
            res_a.last = 1'b1;
            if (n_sat < CW'(2)) begin
              res_a.kind = KIND_DONE;
            end else begin
              res_a.kind          = KIND_REQUEST;
              res_a.second_marker = 12'd1;
            end
          end else if (busy) begin
            rd_en      = 1'b1;
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        wr_en      = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_push   = 1'b1;
        state_next = ST_IDLE;
        if (cur.strong_pair && !w_val[WW-1]) begin
          out_n               = 2'd2;
          res_a.kind          = KIND_BLOCK;
          res_a.first_marker  = 12'(col_index);
          res_a.second_marker = 12'(row_index);
          res_a.span_bp       = cur.span;
          res_a.last          = 1'b0;
          res_b               = res_next;
        end else begin
          res_a = res_next;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      n_cnt          <= '0;
      row_index      <= '0;
      col_index      <= '0;
      row_floor      <= '0;
      next_row_floor <= '0;
      row_sum        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_take && cmd.is_start) begin
            n_cnt     <= n_sat;
            row_sum   <= '0;
            row_floor <= '0;
            col_index <= '0;
            if (n_sat < CW'(2)) begin
              busy           <= 1'b0;
              row_index      <= '0;
              next_row_floor <= '0;
            end else begin
              busy           <= 1'b1;
              row_index      <= IW'(1);
              next_row_floor <= IW'(1);
            end
          end else if (cmd_take && busy) begin
            row_sum <= row_sum_upd;
          end
        end
        ST_UPDATE: begin
        end
        ST_EMIT: begin
          if (col_index > row_floor) begin
            col_index      <= col_index - IW'(1);
            next_row_floor <= nrf_upd;
          end else if ((CW'(row_index) + CW'(1)) < n_cnt) begin
            row_index      <= row_index + IW'(1);
            row_floor      <= nrf_upd;
            next_row_floor <= row_index + IW'(1);
            row_sum        <= '0;
            col_index      <= row_index;
          end else begin
            busy           <= 1'b0;
            next_row_floor <= nrf_upd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: command, bound products and updated weight.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur    <= cmd;
      p_prod <= PW'(p_left) * PW'(p_right);
    end
    if (wr_en) begin
      w_val <= w_new;
      bound <= (HW'(cfg.strong_weight) * HW'(p_prod)) >> 1;
    end
  end

  // Weight memory, one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col_index] <= w_new;
    end
    if (rd_en) begin
      rd_data <= mem[col_index];
    end
  end

  // Two-entry result queue; it is only loaded while empty.
  assign empty  = (out_cnt == 2'd0);
  assign result = oq[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (out_push) begin
      out_cnt <= out_n;
    end else if (pop && !empty) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[0] <= res_a;
      oq[1] <= res_b;
    end else if (pop && !empty) begin
      oq[0] <= oq[1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ld_block_pair_weight_pruner.sv
// Top level of the LD block pair weight pruner: configuration registers,
// front end classifier and back end scan sequencer.
// Depends on lbp_pkg, lbp_front and lbp_back.
//
//   Channel   Handshake            Payload        Transfer when
//   input     push / full          item           push && !full
//   result    pop / empty          result         pop && !empty
//   config    cfg_wen              cfg_index,     cfg_wen
//                                  cfg_wdata
//
// A start is handled in the idle state; an answer steps through the weight read,
// the weight write with the bound product, and the result.
// A command enters the back end only when the result queue is empty.
// Reset is synchronous and returns to idle with reset configuration values.
// The front end queue holds two commands, so up to two items are accepted
// while results stall; after that full stays high.
`default_nettype none

module ld_block_pair_weight_pruner
  import lbp_pkg::*;
#(
  parameter int MAX_MARKERS  = 4096,
  parameter int WEIGHT_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire lbp_item_t   item,
  output logic             empty,
  input  wire logic        pop,
  output lbp_result_t      result,
  input  wire logic        cfg_wen,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  lbp_cfg_t cfg;
  logic     cmd_valid;
  lbp_cmd_t cmd;
  logic     cmd_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_STRONG_POS_LOWER_MIN: cfg.strong_pos_lower_min <= cfg_wdata;
        REG_STRONG_POS_UPPER_MIN: cfg.strong_pos_upper_min <= cfg_wdata;
        REG_STRONG_NEG_UPPER_MAX: cfg.strong_neg_upper_max <= cfg_wdata;
        REG_STRONG_NEG_LOWER_MAX: cfg.strong_neg_lower_max <= cfg_wdata;
        REG_RECOMB_LOWER_MIN:     cfg.recomb_lower_min     <= cfg_wdata;
        REG_RECOMB_UPPER_MAX:     cfg.recomb_upper_max     <= cfg_wdata;
        REG_STRONG_WEIGHT:        cfg.strong_weight        <= cfg_wdata;
        REG_RECOMB_WEIGHT:        cfg.recomb_weight        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and classify.
  lbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Back end: scan, weights and results.
  lbp_back #(
    .MAX_MARKERS  (MAX_MARKERS),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

`ifndef ASSERT_OFF
  // A run finished result always closes its input item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_DONE) |-> result.last)
    else $error("run finished result without last");

  // A candidate block is always followed by a further result.
  a_block_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_BLOCK) |-> !result.last)
    else $error("candidate block marked last");

  // The result queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire

FILE: verif/ld_block_pair_weight_pruner_test.sv
// Testbench for ld_block_pair_weight_pruner: directed and random pair scans checked
// against a built-in scan predictor, over several threshold and weight settings.
// Depends on lbp_pkg and the RTL of ld_block_pair_weight_pruner.
`timescale 1ns / 1ps

module ld_block_pair_weight_pruner_test;
  import lbp_pkg::*;

  localparam int NMARK = 4096;
  localparam longint WMAX = (longint'(1) <<< 47) - 1;
  localparam longint WMIN = -WMAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  lbp_item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  lbp_result_t result;
  logic cfg_wen = 1'b0;
  logic [2:0] cfg_index = REG_STRONG_POS_LOWER_MIN;
  logic [15:0] cfg_wdata = '0;

  ld_block_pair_weight_pruner dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Scan state kept by the predictor.
  lbp_cfg_t thresholds;
  longint pair_weight [NMARK];
  int row_i, col_j, floor_j, next_floor_j, markers;
  longint row_total;
  bit scanning;

  lbp_result_t expected_results[$];
  int error_count = 0;
  int push_gap_max = 16;
  int pop_stall_max = 16;

  function automatic longint clip_add(longint a, longint b);
    if (b > 0 && a > WMAX - b) return WMAX;
    if (b < 0 && a < WMIN - b) return WMIN;
    return a + b;
  endfunction

  function automatic void expect_result(logic [1:0] kind, int first, int second,
                                        logic [31:0] span, logic last);
    lbp_result_t r;
    r.kind = kind;
    r.first_marker = first[11:0];
    r.second_marker = second[11:0];
    r.span_bp = span;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  // Works out the results that one accepted item causes and advances the scan.
  function automatic void predict_scan(lbp_item_t it);
    int n, lo, hi, jj;
    bit strong_pair, recomb;
    longint w, h;
    longint unsigned p;
    if (it.cmd == CMD_START) begin
      n = it.marker_count;
      if (n > NMARK) n = NMARK;
      foreach (pair_weight[k]) pair_weight[k] = 0;
      markers = n;
      row_total = 0;
      floor_j = 0;
      if (n < 2) begin
        scanning = 0;
        row_i = 0; col_j = 0; next_floor_j = 0;
        expect_result(KIND_DONE, 0, 0, '0, 1'b1);
      end else begin
        scanning = 1;
        row_i = 1; col_j = 0; next_floor_j = 1;
        expect_result(KIND_REQUEST, 0, 1, '0, 1'b1);
      end
      return;
    end
    if (!scanning) return;
    lo = int'(it.ci_lower);
    hi = int'(it.ci_upper);
    jj = col_j;
    strong_pair = it.ci_valid &&
      ((lo >= int'(thresholds.strong_pos_lower_min) &&
        hi >= int'(thresholds.strong_pos_upper_min)) ||
       (lo <= int'(thresholds.strong_neg_upper_max) &&
        hi <= int'(thresholds.strong_neg_lower_max)));
    recomb = it.ci_valid && !strong_pair && lo >= int'(thresholds.recomb_lower_min) &&
             hi <= int'(thresholds.recomb_upper_max);
    if (strong_pair) row_total = clip_add(row_total, longint'(thresholds.strong_weight));
    else if (recomb) row_total = clip_add(row_total, -longint'(thresholds.recomb_weight));
    pair_weight[jj] = clip_add(pair_weight[jj], row_total);
    w = pair_weight[jj];
    if (strong_pair && w >= 0)
      expect_result(KIND_BLOCK, col_j, row_i, it.pair_span_bp, 1'b0);
    // Optimistic bound: could later strong pairs still lift this weight to zero?
    p = longint'(markers - row_i - 1) * longint'(markers + row_i - 2 * col_j);
    h = longint'((longint'(thresholds.strong_weight) * p) >> 1);
    if (w >= 0 || -w <= h) next_floor_j = col_j;
    if (col_j > floor_j) begin
      col_j = col_j - 1;
      expect_result(KIND_REQUEST, col_j, row_i, '0, 1'b1);
    end else if (row_i + 1 < markers) begin
      row_i = row_i + 1;
      floor_j = next_floor_j;
      next_floor_j = row_i;
      row_total = 0;
      col_j = row_i - 1;
      expect_result(KIND_REQUEST, col_j, row_i, '0, 1'b1);
    end else begin
      scanning = 0;
      expect_result(KIND_DONE, 0, 0, '0, 1'b1);
    end
  endfunction

  // Sends one item after a random gap and predicts it once the transfer happens.
  task automatic send_item(lbp_item_t it);
    int gap;
    gap = $urandom_range(0, push_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_scan(it);
  endtask

  function automatic lbp_item_t start_item(int n);
    lbp_item_t it;
    it = '0;
    it.cmd = CMD_START;
    it.marker_count = n[12:0];
    it.ci_lower = 16'($urandom);
    it.ci_upper = 16'($urandom);
    it.ci_valid = 1'($urandom);
    it.pair_span_bp = $urandom;
    return it;
  endfunction

  function automatic lbp_item_t answer_item(int lo, int hi, bit ok, logic [31:0] span);
    lbp_item_t it;
    it.cmd = CMD_ANSWER;
    it.marker_count = 13'($urandom);
    it.ci_lower = lo[15:0];
    it.ci_upper = hi[15:0];
    it.ci_valid = ok;
    it.pair_span_bp = span;
    return it;
  endfunction

  // Bound value aimed near the class edges, at the extremes, or anywhere.
  function automatic int pick_bound();
    int sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: return int'(thresholds.strong_pos_lower_min) + $urandom_range(0, 2) - 1;
      1: return int'(thresholds.strong_pos_upper_min) + $urandom_range(0, 2) - 1;
      2: return int'(thresholds.strong_neg_upper_max) + $urandom_range(0, 2) - 1;
      3: return int'(thresholds.recomb_lower_min) + $urandom_range(0, 2) - 1;
      4: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic lbp_item_t random_answer();
    int lo, hi;
    lo = pick_bound();
    hi = pick_bound();
    // Push half the answers deliberately into the positive or negative strong class.
    case ($urandom_range(0, 3))
      0: begin
        lo = $urandom_range(0, 1) ? 32767 : int'(thresholds.strong_pos_lower_min);
        hi = 32767;
      end
      1: begin
        lo = -32768;
        hi = $urandom_range(0, 1) ? -32768 : int'(thresholds.strong_neg_lower_max);
      end
      default: ;
    endcase
    return answer_item(lo, hi, $urandom_range(0, 9) != 0, $urandom);
  endfunction

  // Waits until every expected result has come and the block has settled.
  task automatic drain();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_STRONG_POS_LOWER_MIN: thresholds.strong_pos_lower_min = value;
      REG_STRONG_POS_UPPER_MIN: thresholds.strong_pos_upper_min = value;
      REG_STRONG_NEG_UPPER_MAX: thresholds.strong_neg_upper_max = value;
      REG_STRONG_NEG_LOWER_MAX: thresholds.strong_neg_lower_max = value;
      REG_RECOMB_LOWER_MIN:     thresholds.recomb_lower_min = value;
      REG_RECOMB_UPPER_MAX:     thresholds.recomb_upper_max = value;
      REG_STRONG_WEIGHT:        thresholds.strong_weight = value;
      REG_RECOMB_WEIGHT:        thresholds.recomb_weight = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(lbp_cfg_t c);
    drain();
    write_reg(REG_STRONG_POS_LOWER_MIN, c.strong_pos_lower_min);
    write_reg(REG_STRONG_POS_UPPER_MIN, c.strong_pos_upper_min);
    write_reg(REG_STRONG_NEG_UPPER_MAX, c.strong_neg_upper_max);
    write_reg(REG_STRONG_NEG_LOWER_MAX, c.strong_neg_lower_max);
    write_reg(REG_RECOMB_LOWER_MIN, c.recomb_lower_min);
    write_reg(REG_RECOMB_UPPER_MAX, c.recomb_upper_max);
    write_reg(REG_STRONG_WEIGHT, c.strong_weight);
    write_reg(REG_RECOMB_WEIGHT, c.recomb_weight);
  endtask

  // Short runs, saturation of the marker count, and answers with nothing pending.
  task automatic test_short_runs();
    send_item(start_item(0));
    send_item(start_item(1));
    send_item(answer_item(32767, 32767, 1'b1, 32'hFFFF_FFFF));
    send_item(start_item(8191));
    send_item(answer_item(32767, 32767, 1'b1, 32'hFFFF_FFFF));
    send_item(answer_item(-32768, -32768, 1'b1, 32'h0));
    send_item(start_item(4097));
  endtask

  // A small full scan with each class of pair, an invalid interval and a restart.
  task automatic test_directed_scan();
    send_item(start_item(5));
    send_item(answer_item(32767, 32767, 1'b1, 32'd1000));
    send_item(answer_item(-32768, -32768, 1'b1, 32'hFFFF_FFFF));
    send_item(answer_item(0, 0, 1'b1, 32'd7));
    send_item(answer_item(32767, 32767, 1'b0, 32'd9));
    send_item(answer_item(-32768, 32767, 1'b1, 32'd11));
    send_item(answer_item(22938, 32113, 1'b1, 32'd13));
    send_item(answer_item(-22938, -32113, 1'b1, 32'd15));
    send_item(answer_item(-29491, 29491, 1'b1, 32'd17));
    send_item(start_item(4));
    repeat (8) send_item(answer_item(32767, 32767, 1'b1, $urandom));
  endtask

  // Scans with random content; most runs are driven to completion.
  task automatic random_scans(int budget);
    int sent, n, limit;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        push_gap_max = 0;
        pop_stall_max = 0;
      end else begin
        push_gap_max = 16;
        pop_stall_max = 16;
      end
      case ($urandom_range(0, 19))
        0: n = $urandom_range(0, 8191);
        1: n = $urandom_range(0, 1);
        default: n = $urandom_range(2, 9);
      endcase
      send_item(start_item(n));
      sent++;
      limit = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 10) : 60;
      while (scanning && limit > 0) begin
        send_item(random_answer());
        sent++;
        limit--;
      end
      if ($urandom_range(0, 7) == 0) send_item(random_answer());
    end
  endtask

  task automatic test_reset_settings();
    random_scans(200);
  endtask

  task automatic test_extreme_settings();
    lbp_cfg_t c;
    c = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
          16'hFFFF, 16'hFFFF};
    write_all_regs(c);
    random_scans(120);
    c = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
          16'h0000, 16'h0000};
    write_all_regs(c);
    random_scans(120);
  endtask

  task automatic test_random_settings();
    lbp_cfg_t c;
    repeat (5) begin
      c.strong_pos_lower_min = 16'($urandom_range(0, 32767));
      c.strong_pos_upper_min = 16'($urandom_range(0, 32767));
      c.strong_neg_upper_max = 16'(-$urandom_range(0, 32768));
      c.strong_neg_lower_max = 16'(-$urandom_range(0, 32768));
      c.recomb_lower_min = 16'($urandom);
      c.recomb_upper_max = 16'($urandom);
      c.strong_weight = 16'($urandom);
      c.recomb_weight = 16'($urandom);
      write_all_regs(c);
      random_scans(100);
    end
    write_all_regs(CFG_RESET);
    random_scans(100);
  endtask

  // Result side: random stalls between transfers.
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = $urandom_range(0, pop_stall_max);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin
    lbp_result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind) begin
          $display("%0t: kind: expected %0d, actual %0d", $time, want.kind, result.kind);
          error_count++;
        end
        if (result.first_marker !== want.first_marker) begin
          $display("%0t: first_marker: expected %0d, actual %0d", $time,
                   want.first_marker, result.first_marker);
          error_count++;
        end
        if (result.second_marker !== want.second_marker) begin
          $display("%0t: second_marker: expected %0d, actual %0d", $time,
                   want.second_marker, result.second_marker);
          error_count++;
        end
        if (result.span_bp !== want.span_bp) begin
          $display("%0t: span_bp: expected %0d, actual %0d", $time,
                   want.span_bp, result.span_bp);
          error_count++;
        end
        if (result.last !== want.last) begin
          $display("%0t: last: expected %0b, actual %0b", $time, want.last, result.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    thresholds = CFG_RESET;
    foreach (pair_weight[k]) pair_weight[k] = 0;
    row_i = 0; col_j = 0; floor_j = 0; next_floor_j = 0;
    markers = 0; row_total = 0; scanning = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_runs();
    test_directed_scan();
    test_reset_settings();
    test_extreme_settings();
    test_random_settings();
    drain();
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ld_block_pair_weight_pruner_test: done, clean");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never came", $time, expected_results.size());
      $display("ld_block_pair_weight_pruner_test: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #50ms;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("ld_block_pair_weight_pruner_test: done, errors");
    $finish;
  end

endmodule
